[design/learning_bridge_mac_filter_defines.svh]
// Assertion macros shared by the learning bridge address filter.
// Depends on nothing; the using module supplies clk_i and rst_ni.
`ifndef LEARNING_BRIDGE_MAC_FILTER_DEFINES_SVH
`define LEARNING_BRIDGE_MAC_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge.
`define LBMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge.
`define LBMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBMF_ASSERT_NOW(lbl, ante, cons, msg)
`define LBMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/lbmf_pkg.sv]
// Shared types and constants of the learning bridge address filter.
// Used by the channel interfaces and the top level; depends on nothing.
package lbmf_pkg;

  localparam int unsigned MacW            = 48;
  localparam int unsigned TagW            = 40;
  localparam int unsigned GroupBit        = 40;
  localparam int unsigned TableEntriesDef = 32768;

  typedef logic [MacW-1:0] mac_t;
  typedef logic [TagW-1:0] tag_t;

  // One station table entry: valid, port on which it was learnt, and the
  // first five octets of the station address.
  typedef struct packed {
    logic valid;
    logic port;
    tag_t tag;
  } entry_t;

endpackage

[design/lbmf_ifs.sv]
// Valid/ready channel interfaces of the learning bridge address filter.
// Depends on lbmf_pkg for the address type.
interface lbmf_hdr_if;
  logic           valid;
  logic           ready;
  lbmf_pkg::mac_t dest_address;
  lbmf_pkg::mac_t source_address;
  logic           ingress_port;

  modport source (output valid, dest_address, source_address, ingress_port, input ready);
  modport sink   (input valid, dest_address, source_address, ingress_port, output ready);
endinterface

interface lbmf_res_if;
  logic valid;
  logic ready;
  logic forward;
  logic egress_port;

  modport source (output valid, forward, egress_port, input ready);
  modport sink   (input valid, forward, egress_port, output ready);
endinterface

[design/learning_bridge_mac_filter.sv]
// Top level of the two-port learning bridge address filter.
// Depends on lbmf_pkg, lbmf_ifs.sv and learning_bridge_mac_filter_defines.svh.
`include "learning_bridge_mac_filter_defines.svh"

// Each transfer on req_i carries one frame header and produces exactly one
// transfer on rsp_o, in order. In the cycle of a header's transfer the station
// table is read at the slots of both the destination and the source (a memory
// with two registered read ports); once the output register is free or being
// emptied, the filter decision is made, the source is written back into its
// slot if that slot is empty and the frame is forwarded, and the result is
// loaded into the output register. A new header is not taken until the previous
// one has finished; the output register lets the next header be read while the
// previous result still waits. Group-addressed destinations are always
// forwarded. After reset the table is cleared by a pass that writes one entry
// per cycle, so req_i stays not ready until every entry has been cleared. The
// egress port is always the port other than the ingress port, also for a
// filtered frame.
module learning_bridge_mac_filter #(
  parameter int unsigned TABLE_ENTRIES = lbmf_pkg::TableEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbmf_hdr_if.sink   req_i,
  lbmf_res_if.source rsp_o
);
  import lbmf_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SlotW = 15;

  typedef logic [IdxW-1:0] idx_t;

  // Slot of an address: sixth octet above the low seven bits of the fifth.
  function automatic idx_t slot_of(input mac_t mac);
    logic [SlotW-1:0] raw;
    raw = {mac[7:0], mac[14:8]};
    return idx_t'(raw);
  endfunction

  // Station table.
  entry_t mem [TABLE_ENTRIES];

  // Clearing pass after reset.
  idx_t clr_idx_q, clr_idx_d;
  logic clr_done_q, clr_done_d;

  // Header being worked on.
  logic   busy_q, busy_d;
  logic   dst_group_q;
  tag_t   dst_tag_q;
  tag_t   src_tag_q;
  logic   port_q;
  idx_t   src_idx_q;
  entry_t dst_ent_q;
  entry_t src_ent_q;

  // Output register.
  logic rsp_valid_q, rsp_valid_d;
  logic fwd_q, fwd_d;
  logic egress_q, egress_d;

  logic   accept;
  logic   finish;
  logic   hit;
  logic   learn;
  logic   we;
  idx_t   waddr;
  entry_t wdata;

  assign req_i.ready = clr_done_q && !busy_q;
  assign accept      = req_i.valid && req_i.ready;
  assign finish      = busy_q && (!rsp_valid_q || rsp_o.ready);

  // The frame is filtered when its unicast destination was learnt on the
  // port it arrived on; only forwarded frames offer their source for learning,
  // and an occupied slot is never overwritten.
  assign hit = !dst_group_q && dst_ent_q.valid && (dst_ent_q.port == port_q) &&
               (dst_ent_q.tag == dst_tag_q);
  assign learn = !hit && !src_ent_q.valid;

  always_comb begin
    we    = 1'b0;
    waddr = src_idx_q;
    wdata = '{valid: 1'b1, port: port_q, tag: src_tag_q};
    if (!clr_done_q) begin
      we    = 1'b1;
      waddr = clr_idx_q;
      wdata = '0;
    end else if (finish && learn) begin
      we = 1'b1;
    end
  end

  // Reads happen only on a header transfer, writes only while not ready, so
  // a read and a write never meet in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dst_ent_q   <= mem[slot_of(req_i.dest_address)];
      src_ent_q   <= mem[slot_of(req_i.source_address)];
      src_idx_q   <= slot_of(req_i.source_address);
      dst_group_q <= req_i.dest_address[GroupBit];
      dst_tag_q   <= req_i.dest_address[MacW-1 -: TagW];
      src_tag_q   <= req_i.source_address[MacW-1 -: TagW];
      port_q      <= req_i.ingress_port;
    end
  end

  always_comb begin
    clr_idx_d  = clr_idx_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      clr_idx_d = clr_idx_q + idx_t'(1);
      if (clr_idx_q == idx_t'(TABLE_ENTRIES - 1)) begin
        clr_done_d = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    rsp_valid_d = rsp_valid_q;
    fwd_d       = fwd_q;
    egress_d    = egress_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (finish) begin
      busy_d      = 1'b0;
      rsp_valid_d = 1'b1;
      fwd_d       = !hit;
      egress_d    = !port_q;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      clr_done_q  <= 1'b0;
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      clr_idx_q   <= clr_idx_d;
      clr_done_q  <= clr_done_d;
      busy_q      <= busy_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q    <= fwd_d;
    egress_q <= egress_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.forward     = fwd_q;
  assign rsp_o.egress_port = egress_q;

  // Once the clearing pass has ended it never starts again.
  `LBMF_ASSERT_NEXT(a_clear_once, clr_done_q, clr_done_q, "clearing pass restarted")
  // Learning writes only into an empty slot, and only for a forwarded frame.
  `LBMF_ASSERT_NOW(a_learn_empty, we && clr_done_q, !src_ent_q.valid && !hit,
                   "learning write into an occupied slot or for a filtered frame")
  // A finished header shows up as a result in the next cycle.
  `LBMF_ASSERT_NEXT(a_result_loaded, finish,
                    rsp_o.valid && (rsp_o.forward == $past(!hit)),
                    "finished header did not load the output register")
  // A group destination is never filtered.
  `LBMF_ASSERT_NOW(a_group_fwd, busy_q && dst_group_q, !hit,
                   "group-addressed frame filtered")

endmodule
